// File: hw/rtl/swsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swsm_pkg;

  localparam int unsigned NumDigits = 3;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned PosW      = 2;
  localparam int unsigned SegW      = 7;
  localparam int unsigned EnW       = 3;
  localparam int unsigned ReloadW   = 8;

  localparam logic [ReloadW-1:0] ReloadReset = 8'd20;
  localparam logic [DigitW-1:0]  DigitMax    = 4'd9;

  // Digit positions in scan order.
  localparam logic [PosW-1:0] POS_ONES     = 2'd0;
  localparam logic [PosW-1:0] POS_TENS     = 2'd1;
  localparam logic [PosW-1:0] POS_HUNDREDS = 2'd2;

  // Index into the BCD digit vector.
  localparam int unsigned IdxOnes     = 0;
  localparam int unsigned IdxTens     = 1;
  localparam int unsigned IdxHundreds = 2;

  typedef logic [NumDigits-1:0][DigitW-1:0] bcd_t;

  // What the core hands to the display register for one request.
  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic [PosW-1:0]   pos;
  } swsm_disp_t;

  function automatic logic [SegW-1:0] seg_decode(input logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'h0:    s = 7'h3F;
      4'h1:    s = 7'h06;
      4'h2:    s = 7'h5B;
      4'h3:    s = 7'h4F;
      4'h4:    s = 7'h66;
      4'h5:    s = 7'h6D;
      4'h6:    s = 7'h7D;
      4'h7:    s = 7'h07;
      4'h8:    s = 7'h7F;
      4'h9:    s = 7'h6F;
      4'hA:    s = 7'h77;
      4'hB:    s = 7'h7C;
      4'hC:    s = 7'h39;
      4'hD:    s = 7'h5E;
      4'hE:    s = 7'h79;
      default: s = 7'h71;
    endcase
    return s;
  endfunction

  function automatic logic [EnW-1:0] pos_enable(input logic [PosW-1:0] p);
    logic [EnW-1:0] e;
    case (p)
      POS_TENS:     e = 3'b010;
      POS_HUNDREDS: e = 3'b100;
      default:      e = 3'b001;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stopwatch_seven_segment_mux.sv
// A result appears on the master side in the cycle after its request is accepted.
// Throughput: one request per cycle; the single output register is refilled in the
// same cycle its result is taken, so the slave side only stalls while the master does.
// Reset (rst_ni, asynchronous, active low) clears counters, flags, digit position and
// output valid, and loads the prescaler and its reload register with 20.
`timescale 1ns / 1ps
`default_nettype none

module stopwatch_seven_segment_mux import swsm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] button_level, [7:1] zero
  // Master stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [6:0] segment_pattern, [9:7] digit_enable
  // Configuration.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] AddrReload = 3'd0;

  logic [ReloadW-1:0] reload_q;
  logic               accept;
  swsm_disp_t         disp;
  logic [SegW-1:0]    seg;
  logic [EnW-1:0]     en;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= ReloadReset;
    end else if (psel && penable && pwrite && pready && (paddr == AddrReload)) begin
      reload_q <= pwdata[ReloadW-1:0];
    end
  end

  assign prdata = (paddr == AddrReload) ? {{(32 - ReloadW){1'b0}}, reload_q} : '0;

  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  swsm_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .button_level_i (s_axis_tdata[0]),
    .reload_i       (reload_q),
    .disp_o         (disp)
  );

  swsm_display u_display (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .disp_i    (disp),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .seg_o     (seg),
    .en_o      (en)
  );

  assign m_axis_tdata = {6'b0, en, seg};

endmodule

`default_nettype wire

// File: hw/rtl/swsm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module swsm_core import swsm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic               button_level_i,
  input  wire logic [ReloadW-1:0] reload_i,
  output swsm_disp_t              disp_o
);

  logic [ReloadW-1:0] presc_q, presc_d, presc_dec;
  bcd_t               tenths_q, tenths_d;
  bcd_t               shown_q, shown_d;
  logic               running_q, running_d;
  logic               frozen_q, frozen_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               wrap;
  logic               all_nines;

  always_comb begin
    running_d = running_q;
    frozen_d  = frozen_q;
    if (!button_level_i && !running_q) begin
      running_d = 1'b1;
    end else if (running_q && button_level_i) begin
      frozen_d = 1'b1;
    end else begin
      frozen_d = 1'b0;
    end
  end

  // Down counter that wraps; a reload of zero gives a 256-tick period.
  assign presc_dec = presc_q - 1'b1;
  assign wrap      = (presc_dec == '0);
  assign presc_d   = wrap ? reload_i : presc_dec;

  // The tenths count is kept in BCD, so 999 rolling over to 0 is the all-nines case.
  assign all_nines = (tenths_q[IdxOnes] == DigitMax) && (tenths_q[IdxTens] == DigitMax) &&
                     (tenths_q[IdxHundreds] == DigitMax);

  always_comb begin
    tenths_d = tenths_q;
    if (wrap && running_d) begin
      if (all_nines) begin
        tenths_d = '0;
      end else if (tenths_q[IdxOnes] != DigitMax) begin
        tenths_d[IdxOnes] = tenths_q[IdxOnes] + 1'b1;
      end else if (tenths_q[IdxTens] != DigitMax) begin
        tenths_d[IdxOnes] = '0;
        tenths_d[IdxTens] = tenths_q[IdxTens] + 1'b1;
      end else begin
        tenths_d[IdxOnes]     = '0;
        tenths_d[IdxTens]     = '0;
        tenths_d[IdxHundreds] = tenths_q[IdxHundreds] + 1'b1;
      end
    end
  end

  assign shown_d = frozen_d ? shown_q : tenths_d;

  always_comb begin
    unique case (pos_q)
      POS_ONES: pos_d = POS_TENS;
      POS_TENS: pos_d = POS_HUNDREDS;
      default:  pos_d = POS_ONES;
    endcase
  end

  always_comb begin
    disp_o.pos = pos_d;
    case (pos_d)
      POS_ONES: disp_o.digit = shown_d[IdxOnes];
      POS_TENS: disp_o.digit = shown_d[IdxTens];
      default:  disp_o.digit = shown_d[IdxHundreds];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q   <= ReloadReset;
      tenths_q  <= '0;
      shown_q   <= '0;
      running_q <= 1'b0;
      frozen_q  <= 1'b0;
      pos_q     <= POS_ONES;
    end else if (accept_i) begin
      presc_q   <= presc_d;
      tenths_q  <= tenths_d;
      shown_q   <= shown_d;
      running_q <= running_d;
      frozen_q  <= frozen_d;
      pos_q     <= pos_d;
    end
  end

  a_pos_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == POS_ONES || pos_q == POS_TENS || pos_q == POS_HUNDREDS)
    else $error("digit position out of range");

  a_frozen_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frozen_q |-> running_q)
    else $error("display frozen before the stopwatch started");

  a_running_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |=> running_q)
    else $error("running flag cleared");

  a_bcd_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tenths_q[IdxOnes] <= DigitMax && tenths_q[IdxTens] <= DigitMax &&
    tenths_q[IdxHundreds] <= DigitMax && shown_q[IdxOnes] <= DigitMax &&
    shown_q[IdxTens] <= DigitMax && shown_q[IdxHundreds] <= DigitMax)
    else $error("BCD digit above nine");

  a_frozen_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && frozen_d) |=> $stable(shown_q))
    else $error("shown value moved while frozen");

endmodule

`default_nettype wire

// File: hw/rtl/swsm_display.sv
`timescale 1ns / 1ps
`default_nettype none

module swsm_display import swsm_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire swsm_disp_t     disp_i,
  input  wire logic           m_ready_i,
  output logic                m_valid_o,
  output logic [SegW-1:0]     seg_o,
  output logic [EnW-1:0]      en_o
);

  logic            valid_q, valid_d;
  logic [SegW-1:0] seg_q;
  logic [EnW-1:0]  en_q;

  // A new request may overwrite the result in the same cycle it is taken.
  assign valid_d = load_i | (valid_q & ~m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      seg_q <= seg_decode(disp_i.digit);
      en_q  <= pos_enable(disp_i.pos);
    end
  end

  assign m_valid_o = valid_q;
  assign seg_o     = seg_q;
  assign en_o      = en_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !m_ready_i) |-> !load_i)
    else $error("result overwritten while stalled");

  a_en_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $onehot(en_q))
    else $error("digit enable not one-hot");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not marked valid");

endmodule

`default_nettype wire

// File: tb/swsm_scan_checker.sv
`timescale 1ns / 1ps

module swsm_scan_checker import swsm_pkg::*; #(
  parameter logic [2:0] ReloadAddr = 3'd0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  input  wire logic        s_ready_i,
  input  wire logic [7:0]  s_data_i,
  input  wire logic        m_valid_i,
  input  wire logic        m_ready_i,
  input  wire logic [15:0] m_data_i,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  input  wire logic [31:0] prdata_i,
  input  wire logic        pready_i,
  output int               mismatches_o,
  output int               pending_o
);

  localparam int unsigned CountTop = 999;

  typedef struct packed {
    logic [EnW-1:0]  en;
    logic [SegW-1:0] seg;
  } scan_out_t;

  scan_out_t scan_q[$];

  logic [ReloadW-1:0] reload_q;
  logic [ReloadW-1:0] prescale_q;
  logic [9:0]         tenths_q;
  logic [9:0]         shown_q;
  logic               running_q;
  logic               frozen_q;
  logic [PosW-1:0]    scan_pos_q;

  function automatic logic [SegW-1:0] glyph(input int unsigned d);
    logic [SegW-1:0] s;
    case (d)
      0:       s = 7'h3F;
      1:       s = 7'h06;
      2:       s = 7'h5B;
      3:       s = 7'h4F;
      4:       s = 7'h66;
      5:       s = 7'h6D;
      6:       s = 7'h7D;
      7:       s = 7'h07;
      8:       s = 7'h7F;
      default: s = 7'h6F;
    endcase
    return s;
  endfunction

  // One timer tick: button first, then prescaler, counter, shown value and scan.
  function automatic scan_out_t tick_display(input logic released);
    scan_out_t   o;
    int unsigned digit;
    if (!released && !running_q) begin
      running_q = 1'b1;
    end else if (running_q && released) begin
      frozen_q = 1'b1;
    end else begin
      frozen_q = 1'b0;
    end
    prescale_q = prescale_q - 1'b1;
    if (prescale_q == '0) begin
      if (running_q) begin
        tenths_q = tenths_q + 1'b1;
      end
      prescale_q = reload_q;
      if (tenths_q > CountTop) begin
        tenths_q = '0;
      end
    end
    if (!frozen_q) begin
      shown_q = tenths_q;
    end
    scan_pos_q = (scan_pos_q == POS_HUNDREDS) ? POS_ONES : scan_pos_q + 1'b1;
    case (scan_pos_q)
      POS_ONES: begin
        digit = shown_q % 10;
        o.en  = 3'b001;
      end
      POS_TENS: begin
        digit = (shown_q % 100) / 10;
        o.en  = 3'b010;
      end
      default: begin
        digit = shown_q / 100;
        o.en  = 3'b100;
      end
    endcase
    o.seg = glyph(digit);
    return o;
  endfunction

  task automatic report(input string msg);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    scan_out_t want;
    if (!rst_ni) begin
      reload_q     = ReloadReset;
      prescale_q   = ReloadReset;
      tenths_q     = '0;
      shown_q      = '0;
      running_q    = 1'b0;
      frozen_q     = 1'b0;
      scan_pos_q   = POS_ONES;
      mismatches_o = 0;
      scan_q.delete();
    end else begin
      // The output side always refers to a request taken on an earlier edge.
      if (m_valid_i && m_ready_i) begin
        if (scan_q.size() == 0) begin
          report($sformatf("unexpected result %04h", m_data_i));
        end else begin
          want = scan_q.pop_front();
          if (m_data_i[6:0] !== want.seg) begin
            report($sformatf("segment_pattern exp %02h got %02h", want.seg, m_data_i[6:0]));
          end
          if (m_data_i[9:7] !== want.en) begin
            report($sformatf("digit_enable exp %0d got %0d", want.en, m_data_i[9:7]));
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        scan_q.push_back(tick_display(s_data_i[0]));
      end
      if (psel_i && penable_i && pready_i && paddr_i == ReloadAddr) begin
        if (pwrite_i) begin
          reload_q = pwdata_i[ReloadW-1:0];
        end else if (prdata_i !== {{(32 - ReloadW){1'b0}}, reload_q}) begin
          report($sformatf("prescale_reload read exp %0d got %0d", reload_q, prdata_i));
        end
      end
    end
    pending_o = scan_q.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] ReloadAddr = 3'd0;
  localparam int         CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int  mismatches;
  int  pending;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;
  bit  stall_on = 1'b1;
  int  hold_req = 0;
  int  hold_left = 0;

  stopwatch_seven_segment_mux uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  swsm_scan_checker #(.ReloadAddr(ReloadAddr)) scan_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Display side: random stalls, or a long hold-off counted here once requested.
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= !(stall_on && $urandom_range(99) < 23);
    end
  end

  task automatic send_tick(input logic level);
    while (gaps_on && $urandom_range(99) < 23) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {7'b0, level};
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
  endtask

  // Button held or released in runs of random length.
  task automatic run_ticks(input int unsigned n, input int unsigned press_pct);
    int unsigned left;
    int unsigned run;
    logic        level;
    left = n;
    while (left > 0) begin
      level = ($urandom_range(99) < press_pct) ? 1'b0 : 1'b1;
      run   = $urandom_range(1, 24);
      if (run > left) begin
        run = left;
      end
      repeat (run) send_tick(level);
      left -= run;
    end
  endtask

  task automatic reg_access(input logic wr, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ReloadAddr;
    pwdata  <= {24'b0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle();
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_reload(input logic [7:0] val);
    settle();
    reg_access(1'b1, val);
    reg_access(1'b0, '0);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    reg_access(1'b0, '0);

    // Idle while released, first press starts the count, released freezes the
    // display, held again follows the count across the first prescaler wrap.
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    repeat (8) send_tick(1'b1);
    repeat (12) send_tick(1'b0);

    // Fastest reload: once the prescaler first wraps, the count advances every tick and wraps past 999.
    set_reload(8'd1);
    run_ticks(1100, 85);

    // Reload of 255, no random idling, and a long hold-off on the display side.
    set_reload(8'd255);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    hold_req = 200;
    run_ticks(200, 70);
    gaps_on  = 1'b1;
    stall_on = 1'b1;

    // A zero reload makes the prescaler period 256 ticks.
    set_reload(8'd0);
    run_ticks(300, 60);

    repeat (3) begin
      set_reload(8'($urandom_range(2, 254)));
      run_ticks(70, 70);
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: stopwatch_seven_segment_mux.f
hw/rtl/swsm_pkg.sv
hw/rtl/swsm_core.sv
hw/rtl/swsm_display.sv
hw/rtl/stopwatch_seven_segment_mux.sv
tb/swsm_scan_checker.sv
tb/tb_top.sv
